/* rtl/core/fla_pkg.sv */
package fla_pkg;

    // fixed field widths
    localparam int HANDLE_W   = 9;
    localparam int STATUS_W   = 2;
    localparam int CPB_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // reset value of the chunks-per-block register
    localparam logic [CPB_W-1:0] CPB_RESET = 7'd64;

    // command codes on the input word
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPB  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // classified operation codes handed from front to back
    typedef logic [1:0] t_op;
    localparam t_op OP_ALLOC  = 2'd0;
    localparam t_op OP_FREE   = 2'd1;
    localparam t_op OP_IGNORE = 2'd2;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] handle;
    } t_item;

endpackage

/* rtl/core/fla_front.sv */
module fla_front #(
    parameter int POOL_SIZE = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [fla_pkg::HANDLE_W-1:0]  i_handle,
    input  logic                          i_is_null,
    input  logic                          i_init_busy,
    output logic                          o_q_valid,
    output fla_pkg::t_item                o_q_item,
    input  logic                          i_q_pop
);
    import fla_pkg::*;

    t_item                r_q [QDEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;
    logic [QPTR_W-1:0]    n_wr_ptr;
    logic [QPTR_W-1:0]    n_rd_ptr;
    logic [QCNT_W-1:0]    n_count;
    t_item                w_item;
    logic                 w_push;
    logic                 w_pop;

    // classify the incoming word
    always_comb begin
        w_item.handle = i_handle;
        if (i_cmd == CMD_ALLOC) begin
            w_item.op = OP_ALLOC;
        end else if (i_is_null || (32'(i_handle) >= POOL_SIZE)) begin
            w_item.op = OP_IGNORE;
        end else begin
            w_item.op = OP_FREE;
        end
    end

    // hold off input while the queue is full or the pool is being set up
    assign o_in_stall = (r_count == QCNT_W'(QDEPTH)) || i_init_busy;
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_q_pop && (r_count != '0);

    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_q[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

/* rtl/core/fla_back.sv */
module fla_back #(
    parameter int MAX_BLOCKS = 8,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fla_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fla_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_q_valid,
    input  fla_pkg::t_item                  i_q_item,
    output logic                            o_q_pop,
    output logic                            o_init_busy,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fla_pkg::HANDLE_W-1:0]    o_alloc_handle,
    output logic [fla_pkg::STATUS_W-1:0]    o_status
);
    import fla_pkg::*;

    localparam int POOL_SIZE = MAX_BLOCKS * MAX_CHUNKS;
    localparam int AW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int PW        = $clog2(POOL_SIZE + 1);
    localparam int BW        = $clog2(MAX_BLOCKS + 1);
    localparam int CW        = $clog2(MAX_CHUNKS + 1);
    localparam int INIT_N    = (MAX_CHUNKS < 64) ? MAX_CHUNKS : 64;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    // configuration
    logic [CPB_W-1:0]     r_cpb;
    logic                 r_allow_grow;

    // sequencer and list state
    logic [1:0]           r_state,      n_state;
    logic                 r_init,       n_init;
    logic [AW-1:0]        r_head,       n_head;
    logic                 r_head_null,  n_head_null;
    logic [BW-1:0]        r_blocks,     n_blocks;
    logic [PW-1:0]        r_next_base,  n_next_base;
    logic [AW-1:0]        r_walk_base,  n_walk_base;
    logic [AW-1:0]        r_walk_addr,  n_walk_addr;
    logic [CW-1:0]        r_walk_cnt,   n_walk_cnt;
    logic [CW-1:0]        r_walk_n,     n_walk_n;

    // output slot
    logic                 r_out_valid,  n_out_valid;
    logic [HANDLE_W-1:0]  r_out_handle, n_out_handle;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;

    // link memory: null mark over chunk index
    logic [AW:0]          r_mem [POOL_SIZE];
    logic [AW:0]          r_rdata;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_waddr;
    logic [AW:0]          w_mem_wdata;
    logic                 w_mem_re;
    logic [AW-1:0]        w_mem_raddr;

    logic                 w_slot_free;
    logic                 w_grow_ok;
    logic                 w_walk_last;
    logic [CW-1:0]        w_blk_n;

    // clamp chunks per block into one .. MAX_CHUNKS
    always_comb begin
        if (r_cpb == '0) begin
            w_blk_n = CW'(1);
        end else if (32'(r_cpb) > MAX_CHUNKS) begin
            w_blk_n = CW'(MAX_CHUNKS);
        end else begin
            w_blk_n = CW'(r_cpb);
        end
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_grow_ok   = r_allow_grow && (r_blocks < BW'(MAX_BLOCKS));
    assign w_walk_last = (r_walk_cnt == r_walk_n - CW'(1));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_head       = r_head;
        n_head_null  = r_head_null;
        n_blocks     = r_blocks;
        n_next_base  = r_next_base;
        n_walk_base  = r_walk_base;
        n_walk_addr  = r_walk_addr;
        n_walk_cnt   = r_walk_cnt;
        n_walk_n     = r_walk_n;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_handle = r_out_handle;
        n_out_status = r_out_status;
        o_q_pop      = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_walk_addr;
        w_mem_wdata  = {w_walk_last, r_walk_addr + AW'(1)};
        w_mem_re     = 1'b0;
        w_mem_raddr  = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_slot_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_item.op)
                        OP_ALLOC: begin
                            if (!r_head_null) begin
                                w_mem_re = 1'b1;
                                n_state  = S_READ;
                            end else if (w_grow_ok) begin
                                n_walk_base = AW'(r_next_base);
                                n_walk_addr = AW'(r_next_base);
                                n_walk_cnt  = '0;
                                n_walk_n    = w_blk_n;
                                n_state     = S_WALK;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_handle = '0;
                                n_out_status = ST_OOM;
                            end
                        end
                        OP_FREE: begin
                            // push the chunk as new head
                            w_mem_we     = 1'b1;
                            w_mem_waddr  = AW'(i_q_item.handle);
                            w_mem_wdata  = {r_head_null, r_head};
                            n_head       = AW'(i_q_item.handle);
                            n_head_null  = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out_handle = '0;
                            n_out_status = ST_OK;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_handle = '0;
                            n_out_status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_READ: begin
                // pop head, follow its link
                n_head       = r_rdata[AW-1:0];
                n_head_null  = r_rdata[AW];
                n_out_valid  = 1'b1;
                n_out_handle = HANDLE_W'(r_head);
                n_out_status = ST_OK;
                n_state      = S_IDLE;
            end
            S_WALK: begin
                // link one chunk of the new block per cycle
                w_mem_we    = 1'b1;
                n_walk_addr = r_walk_addr + AW'(1);
                n_walk_cnt  = r_walk_cnt + CW'(1);
                if (w_walk_last) begin
                    n_state = S_IDLE;
                    if (r_init) begin
                        n_init = 1'b0;
                    end else begin
                        // new block grown: hand out its first chunk
                        n_head       = r_walk_base + AW'(1);
                        n_head_null  = (r_walk_n == CW'(1));
                        n_blocks     = r_blocks + BW'(1);
                        n_next_base  = r_next_base + PW'(MAX_CHUNKS);
                        n_out_valid  = 1'b1;
                        n_out_handle = HANDLE_W'(r_walk_base);
                        n_out_status = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WALK;
            r_init       <= 1'b1;
            r_head       <= '0;
            r_head_null  <= 1'b0;
            r_blocks     <= BW'(1);
            r_next_base  <= PW'(MAX_CHUNKS);
            r_walk_base  <= '0;
            r_walk_addr  <= '0;
            r_walk_cnt   <= '0;
            r_walk_n     <= CW'(INIT_N);
            r_out_valid  <= 1'b0;
            r_cpb        <= CPB_RESET;
            r_allow_grow <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_init       <= n_init;
            r_head       <= n_head;
            r_head_null  <= n_head_null;
            r_blocks     <= n_blocks;
            r_next_base  <= n_next_base;
            r_walk_base  <= n_walk_base;
            r_walk_addr  <= n_walk_addr;
            r_walk_cnt   <= n_walk_cnt;
            r_walk_n     <= n_walk_n;
            r_out_valid  <= n_out_valid;
            // register writes
            if (i_cfg_we && (i_cfg_idx == CFG_CPB)) begin
                r_cpb <= i_cfg_wdata[CPB_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_GROW)) begin
                r_allow_grow <= i_cfg_wdata[0];
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
    end

    // link memory port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_raddr];
        end
    end

    assign o_init_busy    = r_init;
    assign o_out_valid    = r_out_valid;
    assign o_alloc_handle = r_out_handle;
    assign o_status       = r_out_status;

endmodule

/* rtl/core/free_list_chunk_allocator.sv */
// Fixed-size chunk pool kept as a last-in first-out free list in a link memory of
// MAX_BLOCKS * MAX_CHUNKS entries. Each word is an alloc (cmd 0) or a free (cmd 1) and
// gives exactly one result word: the allocated handle and a status (ok, out of memory,
// or free ignored for a null or out-of-pool handle). Words enter a two-entry queue, so
// input can still be taken while a result waits on the output stall, until the queue
// is full. Through the single link-memory port a free is handled in S_IDLE, an alloc
// from a non-empty list goes through S_READ (registered link read), and an alloc that
// grows the pool walks S_WALK over n chunks, n being chunks_per_block clamped to
// 1 .. MAX_CHUNKS, one chunk linked per cycle. After reset the block stalls its input
// while block zero is linked; register writes are taken throughout. The user must write
// registers only while no word is in flight; the block itself does not enforce this.
module free_list_chunk_allocator #(
    parameter int MAX_BLOCKS = 8,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fla_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fla_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [fla_pkg::HANDLE_W-1:0]    i_handle,
    input  logic                            i_is_null,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fla_pkg::HANDLE_W-1:0]    o_alloc_handle,
    output logic [fla_pkg::STATUS_W-1:0]    o_status
);
    import fla_pkg::*;

    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_q_pop;
    logic   w_init_busy;

    // accept and classify
    fla_front #(
        .POOL_SIZE (MAX_BLOCKS * MAX_CHUNKS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_handle    (i_handle),
        .i_is_null   (i_is_null),
        .i_init_busy (w_init_busy),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    // list engine
    fla_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_init_busy    (w_init_busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alloc_handle (o_alloc_handle),
        .o_status       (o_status)
    );

endmodule

/* rtl/core/fla_checker.sv */
module fla_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [fla_pkg::HANDLE_W-1:0]    o_alloc_handle,
    input  logic [fla_pkg::STATUS_W-1:0]    o_status
);
    import fla_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_alloc_handle) && $stable(o_status))
        else $error("result word changed under stall");

    // pool setup after reset keeps input closed
    a_init_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open during pool setup");

    // only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_OOM || o_status == ST_IGNORED))
        else $error("undefined status code");

    // failed or ignored words carry a zero handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_alloc_handle == '0))
        else $error("nonzero handle on failed word");

endmodule

bind free_list_chunk_allocator fla_checker u_fla_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_alloc_handle (o_alloc_handle),
    .o_status       (o_status)
);

/* tb/chunk_pool_checker.sv */
`timescale 1ns / 100ps

module chunk_pool_checker #(
    parameter int MAX_BLOCKS = 8,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fla_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fla_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_cmd,
    input  logic [fla_pkg::HANDLE_W-1:0]    i_handle,
    input  logic                            i_is_null,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [fla_pkg::HANDLE_W-1:0]    i_alloc_handle,
    input  logic [fla_pkg::STATUS_W-1:0]    i_status,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_grows,
    output int                              o_ooms
);
    import fla_pkg::*;

    localparam int POOL_SIZE = MAX_BLOCKS * MAX_CHUNKS;

    // one entry of the link memory: successor index and end-of-list mark
    typedef struct packed {
        logic       last;
        logic [9:0] nxt;
    } t_chunk_link;

    // one answer word as the block should return it
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } t_pool_answer;

    t_chunk_link      link_mem [POOL_SIZE];
    logic [9:0]       free_head;
    logic             list_empty;
    int unsigned      blocks_grown;
    logic [CPB_W-1:0] cpb_reg;
    logic             grow_en;

    t_pool_answer     pending_answers [$];
    int               error_count = 0;
    int               grow_count  = 0;
    int               oom_count   = 0;

    // link the chunks of a fresh block in order and make them the whole list
    task automatic link_new_block(input int unsigned blk);
        int unsigned n;
        int unsigned base;
        int unsigned i;
        n = 32'(cpb_reg);
        if (n < 1) n = 1;
        if (n > MAX_CHUNKS) n = MAX_CHUNKS;
        base = blk * MAX_CHUNKS;
        for (i = 0; i < n; i++) begin
            if (base + i >= POOL_SIZE) break;
            link_mem[base + i].nxt  = 10'(base + i + 1);
            link_mem[base + i].last = (i + 1 >= n);
        end
        free_head  = 10'(base);
        list_empty = 1'b0;
    endtask

    task automatic reset_pool();
        foreach (link_mem[k]) begin
            link_mem[k].last = 1'b1;
            link_mem[k].nxt  = '0;
        end
        cpb_reg      = CPB_RESET;
        grow_en      = 1'b1;
        blocks_grown = 1;
        link_new_block(0);
    endtask

    // pool update for one accepted word, returning the answer it must produce
    task automatic predict_pool_op(input logic cmd, input logic [HANDLE_W-1:0] handle,
                                   input logic is_null, output t_pool_answer answer);
        logic [9:0] popped;
        answer.handle = '0;
        answer.status = ST_OK;
        if (cmd == CMD_ALLOC) begin
            // empty list: add a block if allowed and one is left
            if (list_empty && grow_en && blocks_grown < MAX_BLOCKS) begin
                link_new_block(blocks_grown);
                blocks_grown++;
                grow_count++;
            end
            if (list_empty || free_head >= POOL_SIZE) begin
                answer.status = ST_OOM;
                oom_count++;
            end else begin
                popped        = free_head;
                answer.handle = popped[HANDLE_W-1:0];
                list_empty    = link_mem[popped[HANDLE_W-1:0]].last;
                free_head     = link_mem[popped[HANDLE_W-1:0]].nxt;
            end
        end else if (is_null || handle >= POOL_SIZE) begin
            answer.status = ST_IGNORED;
        end else begin
            // push without any check, double frees included
            link_mem[handle].nxt  = free_head;
            link_mem[handle].last = list_empty;
            free_head             = {1'b0, handle};
            list_empty            = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pool_answer answer;
        t_pool_answer want;
        if (!i_rst_n) begin
            reset_pool();
            pending_answers.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CPB) begin
                    cpb_reg = i_cfg_wdata[CPB_W-1:0];
                end else if (i_cfg_idx == CFG_GROW) begin
                    grow_en = i_cfg_wdata[0];
                end
            end

            // accepted input word
            if (i_in_valid && !i_in_stall) begin
                predict_pool_op(i_cmd, i_handle, i_is_null, answer);
                pending_answers.push_back(answer);
            end

            // accepted result word against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (pending_answers.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected: handle %0d status %0d",
                             $time, i_alloc_handle, i_status);
                end else begin
                    want = pending_answers.pop_front();
                    if (i_alloc_handle !== want.handle) begin
                        error_count++;
                        $display("%0t: alloc_handle expected %0d, got %0d",
                                 $time, want.handle, i_alloc_handle);
                    end
                    if (i_status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
        end
        o_errors  <= error_count;
        o_pending <= pending_answers.size();
        o_grows   <= grow_count;
        o_ooms    <= oom_count;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import fla_pkg::*;

    localparam int      CLK_PERIOD   = 20;
    localparam int      RESET_CYCLES = 11;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      DRAIN_LIMIT  = 20000;
    localparam int      TAIL_CYCLES  = 80;
    localparam longint  TIMEOUT_NS   = 64'd20_000_000;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = CFG_CPB;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   i_cmd       = CMD_ALLOC;
    logic [HANDLE_W-1:0]    i_handle    = '0;
    logic                   i_is_null   = 1'b0;
    logic                   i_out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [HANDLE_W-1:0]    o_alloc_handle;
    logic [STATUS_W-1:0]    o_status;

    int                     errors;
    int                     pending;
    int                     grows;
    int                     ooms;

    int                     idle_pct     = 0;
    int                     stall_pct    = 0;
    int                     pressure_req = 0;
    bit                     track_live   = 1'b0;
    logic [HANDLE_W-1:0]    live_q [$];
    int                     n_alloc = 0;
    int                     n_free  = 0;
    int                     n_null  = 0;

    free_list_chunk_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_handle       (i_handle),
        .i_is_null      (i_is_null),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alloc_handle (o_alloc_handle),
        .o_status       (o_status)
    );

    chunk_pool_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_handle       (i_handle),
        .i_is_null      (i_is_null),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_alloc_handle (o_alloc_handle),
        .i_status       (o_status),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_grows        (grows),
        .o_ooms         (ooms)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // result side: random stall, or a long hold when asked for
    initial begin : receiver
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever begin
            @(posedge i_clk);
            if (served != pressure_req) begin
                served    = pressure_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // collect granted chunks so that frees mostly return live handles
    // (chunk 0 is left out, its answer looks like a free)
    always @(negedge i_clk) begin
        if (track_live && o_out_valid && !i_out_stall && o_status == ST_OK &&
            o_alloc_handle != '0) begin
            live_q.push_back(o_alloc_handle);
        end
    end

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic cmd, input logic [HANDLE_W-1:0] handle,
                             input logic is_null);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_handle   <= handle;
        i_is_null  <= is_null;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (cmd == CMD_ALLOC) n_alloc++;
        else if (is_null) n_null++;
        else n_free++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input int cpb, input logic grow);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_CPB;
        i_cfg_wdata <= cpb[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx   <= CFG_GROW;
        i_cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, grow};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly allocs and frees of live chunks, some null frees as noise
    task automatic random_word(input int alloc_pct);
        int                  roll;
        int                  pick;
        logic [HANDLE_W-1:0] h;
        roll = $urandom_range(99);
        if (roll < alloc_pct) begin
            send_word(CMD_ALLOC, HANDLE_W'($urandom_range(511)), 1'($urandom_range(1)));
        end else if (roll >= 92 || live_q.size() == 0) begin
            send_word(CMD_FREE, HANDLE_W'($urandom_range(511)), 1'b1);
        end else begin
            pick = $urandom_range(live_q.size() - 1);
            h    = live_q[pick];
            live_q.delete(pick);
            send_word(CMD_FREE, h, 1'b0);
        end
    endtask

    task automatic run_random(input int count, input int alloc_pct);
        repeat (count) random_word(alloc_pct);
    endtask

    initial begin : stimulus
        logic [HANDLE_W-1:0] h;
        int                  guard;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the reset settings (64 chunks per block, growing on)
        send_word(CMD_ALLOC, 9'h1ff, 1'b1);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_ALLOC, 9'h0aa, 1'b1);
        send_word(CMD_FREE,  9'd1,   1'b0);
        send_word(CMD_ALLOC, 9'h155, 1'b0);
        // null frees are ignored whatever the handle
        send_word(CMD_FREE,  9'h000, 1'b1);
        send_word(CMD_FREE,  9'h1ff, 1'b1);
        // foreign handle from a block not grown yet
        send_word(CMD_FREE,  9'd511, 1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_FREE,  9'd511, 1'b0);
        send_word(CMD_FREE,  9'd2,   1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_FREE,  9'd0,   1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        // hand everything back
        send_word(CMD_FREE,  9'd3,   1'b0);
        send_word(CMD_FREE,  9'd511, 1'b0);
        send_word(CMD_FREE,  9'd2,   1'b0);
        send_word(CMD_FREE,  9'd1,   1'b0);
        send_word(CMD_FREE,  9'd0,   1'b0);
        wait_drained();
        track_live = 1'b1;

        // growing off: drain block zero into out-of-memory
        set_config(64, 1'b0);
        run_random(250, 75);
        wait_drained();

        // count above the block size is clamped, sender idles
        idle_pct = 55;
        set_config(65, 1'b1);
        run_random(250, 75);
        wait_drained();

        // count of zero grows one chunk at a time until all blocks are used
        idle_pct = 0;
        stall_pct <= 55;
        set_config(0, 1'b1);
        run_random(250, 90);
        wait_drained();

        // long result holds fill the block and stall its input
        stall_pct <= 16;
        set_config(127, 1'b0);
        pressure_req <= pressure_req + 1;
        run_random(125, 50);
        pressure_req <= pressure_req + 1;
        run_random(125, 50);
        wait_drained();

        // free-heavy stretch, cycling through the idling modes
        set_config(1, 1'b1);
        for (int m = 0; m < 5; m++) begin
            idle_pct  = (m % 4 == 1) ? 55 : (m % 4 == 3) ? 16 : 0;
            stall_pct <= (m % 4 == 2) ? 55 : (m % 4 == 3) ? 16 : 0;
            run_random(165, 40);
        end
        wait_drained();

        // double free last: it leaves a chunk linked to itself for good
        track_live = 1'b0;
        idle_pct   = 0;
        stall_pct  <= 0;
        h = (live_q.size() != 0) ? live_q.pop_back() : 9'd5;
        send_word(CMD_FREE,  h,      1'b0);
        send_word(CMD_FREE,  h,      1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_ALLOC, 9'h000, 1'b0);
        send_word(CMD_FREE,  h,      1'b1);

        // let the last results come out
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words (%0d allocs, %0d frees, %0d null frees) over 6 settings",
                 n_alloc + n_free + n_null, n_alloc, n_free, n_null);
        $display("predicted %0d pool growths and %0d out-of-memory answers", grows, ooms);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pending != 0)
                $display("%0t: %0d expected results never arrived", $time, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
